// ===== design/tsb_pkg.sv =====
// shared types and constants for the timer slot bank
package tsb_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned PERIOD_W = 31;
  localparam int unsigned INCR_W   = 32;
  localparam int unsigned SLOT_W   = 4;

  localparam logic [INCR_W-1:0] INCR_RESET = 32'd54945055;

  // packed slot entry: callback flag, reload period, expiry time
  localparam int unsigned ENTRY_W  = TIME_W + PERIOD_W + 1;
  localparam int unsigned EXP_LSB  = 0;
  localparam int unsigned PER_LSB  = TIME_W;
  localparam int unsigned CB_BIT   = TIME_W + PERIOD_W;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_SET_ACK    = 3'd0,
    KIND_CANCEL_ACK = 3'd1,
    KIND_STATE      = 3'd2,
    KIND_EXPIRED    = 3'd3,
    KIND_TICK_DONE  = 3'd4
  } kind_t;

endpackage

// ===== design/tsb_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
module tsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic             re;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/timer_slot_bank_core.sv =====
// timer slot bank: set, cancel, read and tick operations over a bank of slots
//
//   channel   signals                                          direction
//   in        in_valid in_ready func slot due_time period      input
//             has_callback
//   out       out_valid out_ready kind slot_out flag           output
//             time_value last
//   config    tick_step_we tick_step                           input
//
// set, cancel and read give one result each.
// a tick walks the slots in order: when the output is taken at once, one
// slot entry per cycle is read from the slot ram and checked by the single
// compare and reload adder, then the tick done result follows.
// a fired slot stalls the walk while the output register is still full.
// reset clears the clock, the running and signaled flags; slot ram needs none.
module timer_slot_bank_core
  import tsb_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_step_we,
  input  logic [INCR_W-1:0]    tick_step,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [SLOT_W-1:0]    slot,
  input  logic signed [TIME_W-1:0] due_time,
  input  logic [PERIOD_W-1:0]  period,
  input  logic                 has_callback,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           kind,
  output logic [SLOT_W-1:0]    slot_out,
  output logic                 flag,
  output logic [TIME_W-1:0]    time_value,
  output logic                 last
);

  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t state;

  logic [INCR_W-1:0]    incr;
  logic [TIME_W-1:0]    system_clock;
  logic [NUM_SLOTS-1:0] running;
  logic [NUM_SLOTS-1:0] signaled;
  logic [AW-1:0]        idx;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic                 slot_ok;
  logic [AW-1:0]        slot_addr;
  logic [AW+SLOT_W-1:0] slot_ext;
  logic [AW+SLOT_W-1:0] idx_ext;
  logic [SLOT_W-1:0]    idx_slot;
  logic [TIME_W-1:0]    set_exp;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [TIME_W-1:0]    rd_exp;
  logic [PERIOD_W-1:0]  rd_per;
  logic                 rd_cb;
  logic [TIME_W-1:0]    reload_exp;
  logic                 fire;
  logic                 advance;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign slot_ok   = (int'(slot) < int'(NUM_SLOTS));
  assign slot_ext  = {{AW{1'b0}}, slot};
  assign slot_addr = slot_ext[AW-1:0];
  assign idx_ext   = {{SLOT_W{1'b0}}, idx};
  assign idx_slot  = idx_ext[SLOT_W-1:0];

  // negative due time is relative to the current clock
  assign set_exp = due_time[TIME_W-1] ? (system_clock - $unsigned(due_time))
                                      : $unsigned(due_time);

  assign rd_exp     = ram_rdata[EXP_LSB +: TIME_W];
  assign rd_per     = ram_rdata[PER_LSB +: PERIOD_W];
  assign rd_cb      = ram_rdata[CB_BIT];
  assign reload_exp = rd_exp + {{(TIME_W-PERIOD_W){1'b0}}, rd_per};

  assign fire    = (state == ST_WALK) && running[idx] && (system_clock >= rd_exp);
  assign advance = (state == ST_WALK) && (!fire || out_free);

  // a new result enters the output register this cycle
  assign out_load = (accept && (func != FUNC_TICK)) || (advance && fire) ||
                    ((state == ST_DONE) && out_free);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_addr;
    ram_wdata = {has_callback, period, set_exp};
    if (state == ST_WALK) begin
      ram_waddr = idx;
      ram_wdata = {rd_cb, rd_per, reload_exp};
      ram_we    = advance && fire && (rd_per != '0);
    end else begin
      ram_we    = accept && (func == FUNC_SET) && slot_ok;
    end
  end

  // prefetch the next slot entry while the current one is checked
  always_comb begin
    if (state == ST_WALK) begin
      ram_re    = advance && (idx != LAST_IDX);
      ram_raddr = idx + AW'(1);
    end else begin
      ram_re    = accept && (func == FUNC_TICK);
      ram_raddr = '0;
    end
  end

  tsb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      incr         <= INCR_RESET;
      system_clock <= '0;
      running      <= '0;
      signaled     <= '0;
      idx          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (tick_step_we) begin
        incr <= tick_step;
      end
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            slot_out   <= slot;
            time_value <= '0;
            last       <= 1'b1;
            case (func)
              FUNC_TICK: begin
                system_clock <= system_clock + {{(TIME_W-INCR_W){1'b0}}, incr};
                idx          <= '0;
                state        <= ST_WALK;
              end
              FUNC_SET: begin
                out_valid <= 1'b1;
                kind      <= KIND_SET_ACK;
                flag      <= slot_ok && running[slot_addr];
                if (slot_ok) begin
                  running[slot_addr]  <= 1'b1;
                  signaled[slot_addr] <= 1'b0;
                end
              end
              FUNC_CANCEL: begin
                out_valid <= 1'b1;
                kind      <= KIND_CANCEL_ACK;
                flag      <= slot_ok && running[slot_addr];
                if (slot_ok) begin
                  running[slot_addr] <= 1'b0;
                end
              end
              default: begin
                out_valid <= 1'b1;
                kind      <= KIND_STATE;
                flag      <= slot_ok && signaled[slot_addr];
              end
            endcase
          end
        end
        ST_WALK: begin
          if (advance) begin
            if (fire) begin
              out_valid     <= 1'b1;
              kind          <= KIND_EXPIRED;
              slot_out      <= idx_slot;
              flag          <= rd_cb;
              time_value    <= rd_exp;
              last          <= 1'b0;
              signaled[idx] <= 1'b1;
              if (rd_per == '0) begin
                running[idx] <= 1'b0;
              end
            end
            if (idx == LAST_IDX) begin
              state <= ST_DONE;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            kind       <= KIND_TICK_DONE;
            slot_out   <= '0;
            flag       <= 1'b0;
            time_value <= system_clock;
            last       <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
